/* rtl/ndc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_pkg - shared types and constants of the index/coordinate converter
// Word formats, configuration layout, register indexes, operation and error
// codes, and the interface of the shared add/subtract step unit.
// ----------------------------------------------------------------------------
package ndc_pkg;

    localparam int MAX_DIM_DEF   = 4;
    localparam int PACK_BITS_DEF = 32;

    localparam int NUM_AXES  = 5;
    localparam int AX_W      = 3;
    localparam int IDX_W     = 31;
    localparam int CRD_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int MUL_STEPS = 16;
    localparam int DIV_STEPS = 31;
    localparam int CNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SIZE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SIZE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_SIZE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS_SIZE   = 3'd6;

    localparam logic OP_TO_INDEX = 1'b0;
    localparam logic OP_TO_COORD = 1'b1;

    localparam logic [1:0] ERR_OK  = 2'd0;
    localparam logic [1:0] ERR_CFG = 2'd1;
    localparam logic [1:0] ERR_OVF = 2'd2;

    typedef struct packed {
        logic [2:0]       dim_count;
        logic [6:0]       sample_bits;
        logic [7:0]       channel_count;
        logic [CRD_W-1:0] width_size;
        logic [CRD_W-1:0] height_size;
        logic [CRD_W-1:0] frames_size;
        logic [CRD_W-1:0] layers_size;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        dim_count:     3'd2,
        sample_bits:   7'd8,
        channel_count: 8'd1,
        width_size:    16'd1,
        height_size:   16'd1,
        frames_size:   16'd1,
        layers_size:   16'd1
    };

    typedef struct packed {
        logic             op;
        logic [CRD_W-1:0] coord_c;
        logic [CRD_W-1:0] coord_x;
        logic [CRD_W-1:0] coord_y;
        logic [CRD_W-1:0] coord_f;
        logic [CRD_W-1:0] coord_l;
        logic [IDX_W-1:0] linear_index;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] index_out;
        logic [CRD_W-1:0] out_c;
        logic [CRD_W-1:0] out_x;
        logic [CRD_W-1:0] out_y;
        logic [CRD_W-1:0] out_f;
        logic [CRD_W-1:0] out_l;
        logic [1:0]       error_code;
    } t_out_word;

    typedef struct packed {
        logic build;
        logic start;
        logic take;
    } t_eng_req;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_sts;

    typedef enum logic [1:0] {
        STEP_ADD = 2'd0,
        STEP_MUL = 2'd1,
        STEP_DIV = 2'd2
    } t_step_kind;

    typedef struct packed {
        logic [IDX_W-1:0] acc;
        logic [IDX_W-1:0] aux;
        logic             ovf;
    } t_step_res;

endpackage
`default_nettype wire

/* rtl/nd_index_coord_converter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nd_index_coord_converter - row-major index/coordinate converter
// Converts (c, x, y, f, l) to a linear element index and back, using strides
// derived from the configured shape.
// ----------------------------------------------------------------------------
// One word is taken at a time. Coordinates to index (op 0) runs, for each
// dimension in use (channel included), a 16-step shift-add multiply and one
// accumulate on the shared adder. Index to coordinates (op 1) runs the 31-step
// restoring divide on the same adder for each dimension with a nonzero stride
// and skips each dimension with a zero stride.
// After reset and after every configuration write the stride table is rebuilt
// on that adder, and no input word is taken until it is done. A finished
// result waits in the output register while the next word is taken. Error
// code 1 flags an invalid sample size or channel count, error code 2 a stride
// or index beyond 31 bits.
// ----------------------------------------------------------------------------
module nd_index_coord_converter #(
    parameter int MAX_DIM   = ndc_pkg::MAX_DIM_DEF,
    parameter int PACK_BITS = ndc_pkg::PACK_BITS_DEF
) (
    input  var logic                              i_clk,
    input  var logic                              i_rst_n,
    input  var logic                              i_in_valid,
    output logic                                  o_in_ready,
    input  var ndc_pkg::t_in_word                 i_in_word,
    output logic                                  o_out_valid,
    input  var logic                              i_out_ready,
    output ndc_pkg::t_out_word                    o_out_word,
    input  var logic                              i_cfg_we,
    input  var logic [ndc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  var logic [ndc_pkg::CFG_W-1:0]         i_cfg_data
);

    ndc_pkg::t_cfg      r_cfg, n_cfg;
    logic               r_out_valid, n_out_valid;
    ndc_pkg::t_out_word r_out, n_out;
    ndc_pkg::t_eng_req  w_req;
    ndc_pkg::t_eng_sts  w_sts;
    ndc_pkg::t_out_word w_res;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                ndc_pkg::CFG_DIM_COUNT:     n_cfg.dim_count     = i_cfg_data[2:0];
                ndc_pkg::CFG_SAMPLE_BITS:   n_cfg.sample_bits   = i_cfg_data[6:0];
                ndc_pkg::CFG_CHANNEL_COUNT: n_cfg.channel_count = i_cfg_data[7:0];
                ndc_pkg::CFG_WIDTH_SIZE:    n_cfg.width_size    = i_cfg_data;
                ndc_pkg::CFG_HEIGHT_SIZE:   n_cfg.height_size   = i_cfg_data;
                ndc_pkg::CFG_FRAMES_SIZE:   n_cfg.frames_size   = i_cfg_data;
                ndc_pkg::CFG_LAYERS_SIZE:   n_cfg.layers_size   = i_cfg_data;
                default:                    n_cfg               = r_cfg;
            endcase
        end
    end

    assign o_in_ready  = w_sts.idle && !i_cfg_we;
    assign w_req.build = i_cfg_we;
    assign w_req.start = i_in_valid && o_in_ready;
    assign w_req.take  = w_sts.done && (!r_out_valid || i_out_ready);

    ndc_engine #(
        .MAX_DIM   (MAX_DIM),
        .PACK_BITS (PACK_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_cfg   (r_cfg),
        .i_in    (i_in_word),
        .o_sts   (w_sts),
        .o_out   (w_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_req.take) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= ndc_pkg::CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

/* rtl/ndc_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_step - shared add/subtract step unit
// One adder/subtractor serves a plain add, one shift-add multiply step
// (multiplier MSB first) and one restoring divide step (quotient into aux).
// ----------------------------------------------------------------------------
module ndc_step (
    input  var ndc_pkg::t_step_kind              i_kind,
    input  var logic [ndc_pkg::IDX_W-1:0]        i_acc,
    input  var logic [ndc_pkg::IDX_W-1:0]        i_aux,
    input  var logic [ndc_pkg::IDX_W-1:0]        i_opd,
    output ndc_pkg::t_step_res                   o_res
);

    logic [ndc_pkg::IDX_W+1:0] w_a;
    logic [ndc_pkg::IDX_W+1:0] w_b;
    logic                      w_sub;
    logic [ndc_pkg::IDX_W+2:0] w_sum;
    logic                      w_ovf;
    logic                      w_take;

    always_comb begin
        w_a   = {2'b00, i_acc};
        w_b   = {2'b00, i_opd};
        w_sub = 1'b0;
        case (i_kind)
            ndc_pkg::STEP_ADD: begin
                w_a   = {2'b00, i_acc};
                w_b   = {2'b00, i_opd};
                w_sub = 1'b0;
            end
            ndc_pkg::STEP_MUL: begin
                w_a   = {1'b0, i_acc, 1'b0};
                w_b   = i_aux[ndc_pkg::CRD_W-1] ? {2'b00, i_opd} : '0;
                w_sub = 1'b0;
            end
            ndc_pkg::STEP_DIV: begin
                w_a   = {1'b0, i_acc, i_aux[ndc_pkg::IDX_W-1]};
                w_b   = {2'b00, i_opd};
                w_sub = 1'b1;
            end
            default: begin
                w_a   = {2'b00, i_acc};
                w_b   = {2'b00, i_opd};
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_sum  = w_sub ? ({1'b0, w_a} - {1'b0, w_b}) : ({1'b0, w_a} + {1'b0, w_b});
    assign w_ovf  = (w_sum[ndc_pkg::IDX_W+2:ndc_pkg::IDX_W] != 3'b000);
    assign w_take = !w_sum[ndc_pkg::IDX_W+2];

    always_comb begin
        o_res.acc = i_acc;
        o_res.aux = i_aux;
        o_res.ovf = 1'b0;
        case (i_kind)
            ndc_pkg::STEP_ADD: begin
                o_res.acc = w_ovf ? i_acc : w_sum[ndc_pkg::IDX_W-1:0];
                o_res.ovf = w_ovf;
            end
            ndc_pkg::STEP_MUL: begin
                // hold the partial product once it passes 31 bits
                o_res.acc = w_ovf ? i_acc : w_sum[ndc_pkg::IDX_W-1:0];
                o_res.aux = {i_aux[ndc_pkg::IDX_W-2:0], 1'b0};
                o_res.ovf = w_ovf;
            end
            ndc_pkg::STEP_DIV: begin
                o_res.acc = w_take ? w_sum[ndc_pkg::IDX_W-1:0] : w_a[ndc_pkg::IDX_W-1:0];
                o_res.aux = {i_aux[ndc_pkg::IDX_W-2:0], w_take};
            end
            default: begin
                o_res.acc = i_acc;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/ndc_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_engine - stride builder and conversion sequencer
// Builds the stride table after reset and each configuration write, then runs
// dot products (multiply-accumulate) or successive divisions on one step unit.
// ----------------------------------------------------------------------------
module ndc_engine #(
    parameter int MAX_DIM   = ndc_pkg::MAX_DIM_DEF,
    parameter int PACK_BITS = ndc_pkg::PACK_BITS_DEF
) (
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var ndc_pkg::t_eng_req i_req,
    input  var ndc_pkg::t_cfg     i_cfg,
    input  var ndc_pkg::t_in_word i_in,
    output ndc_pkg::t_eng_sts     o_sts,
    output ndc_pkg::t_out_word    o_out
);

    localparam int DIM_LIM = (MAX_DIM < ndc_pkg::NUM_AXES - 1) ? MAX_DIM : ndc_pkg::NUM_AXES - 1;
    localparam int NSLOT   = DIM_LIM + 1;
    localparam int DW      = $clog2(NSLOT);
    localparam int IW      = ndc_pkg::IDX_W;
    localparam int CW      = ndc_pkg::CRD_W;

    localparam logic [ndc_pkg::CNT_W-1:0] MUL_LAST = ndc_pkg::CNT_W'(ndc_pkg::MUL_STEPS - 1);
    localparam logic [ndc_pkg::CNT_W-1:0] DIV_LAST = ndc_pkg::CNT_W'(ndc_pkg::DIV_STEPS - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_BLD  = 7'b0000010,
        S_DISP = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_ADD  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_bld, n_bld;
    logic                       r_ph, n_ph;
    logic [DW-1:0]              r_dim, n_dim;
    logic [ndc_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [DW-1:0]              r_top, n_top;
    logic [DW-1:0]              r_built, n_built;
    logic                       r_bad, n_bad;
    logic                       r_sovf, n_sovf;
    logic [IW-1:0]              r_st [NSLOT];
    logic [IW-1:0]              n_st [NSLOT];
    logic [IW-1:0]              r_prev, n_prev;
    ndc_pkg::t_in_word          r_in, n_in;
    logic [IW-1:0]              r_acc, n_acc;
    logic [IW-1:0]              r_aux, n_aux;
    logic [IW-1:0]              r_mc, n_mc;
    logic                       r_movf, n_movf;
    logic [IW-1:0]              r_sum, n_sum;
    logic [IW-1:0]              r_rem, n_rem;
    logic [CW-1:0]              r_oc [NSLOT];
    logic [CW-1:0]              n_oc [NSLOT];
    logic [1:0]                 r_err, n_err;

    logic [CW-1:0]              w_sz  [ndc_pkg::NUM_AXES];
    logic [CW-1:0]              w_crd [ndc_pkg::NUM_AXES];
    logic [CW-1:0]              w_ocf [ndc_pkg::NUM_AXES];
    logic [ndc_pkg::AX_W-1:0]   w_szi;
    logic [ndc_pkg::AX_W-1:0]   w_cri;
    logic                       w_cfg_bad;
    logic                       w_packed;
    logic [DW-1:0]              w_top;
    logic                       w_bld_end;
    logic                       w_top_end;
    logic                       w_lastd;
    logic                       w_ok_idx;
    logic                       w_ok_crd;
    ndc_pkg::t_step_kind        w_kind;
    logic [IW-1:0]              w_sacc;
    logic [IW-1:0]              w_sopd;
    ndc_pkg::t_step_res         w_stp;

    assign w_sz[0] = CW'(i_cfg.channel_count);
    assign w_sz[1] = i_cfg.width_size;
    assign w_sz[2] = i_cfg.height_size;
    assign w_sz[3] = i_cfg.frames_size;
    assign w_sz[4] = i_cfg.layers_size;

    assign w_crd[0] = r_in.coord_c;
    assign w_crd[1] = r_in.coord_x;
    assign w_crd[2] = r_in.coord_y;
    assign w_crd[3] = r_in.coord_f;
    assign w_crd[4] = r_in.coord_l;

    assign w_szi = ndc_pkg::AX_W'(r_dim) - 3'd1;
    assign w_cri = ndc_pkg::AX_W'(r_dim);

    assign w_packed  = (i_cfg.sample_bits == 7'd1);
    assign w_cfg_bad = (w_packed && i_cfg.channel_count != 8'd1)
                     || (!w_packed && i_cfg.sample_bits < 7'd8);
    assign w_top     = (i_cfg.dim_count == 3'd0) ? DW'(1)
                     : (i_cfg.dim_count > 3'(DIM_LIM)) ? DW'(DIM_LIM)
                     : DW'(i_cfg.dim_count);

    assign w_bld_end = (r_dim == r_built);
    assign w_top_end = (r_dim == r_top);
    assign w_lastd   = (r_dim == '0);

    always_comb begin
        w_kind = ndc_pkg::STEP_ADD;
        case (r_state)
            S_MUL:   w_kind = ndc_pkg::STEP_MUL;
            S_DIV:   w_kind = ndc_pkg::STEP_DIV;
            default: w_kind = ndc_pkg::STEP_ADD;
        endcase
    end

    assign w_sacc = (r_state == S_ADD) ? r_sum : r_acc;
    assign w_sopd = (r_state == S_ADD) ? r_acc : r_mc;

    ndc_step u_step (
        .i_kind (w_kind),
        .i_acc  (w_sacc),
        .i_aux  (r_aux),
        .i_opd  (w_sopd),
        .o_res  (w_stp)
    );

    always_comb begin
        n_state = r_state;
        n_bld   = r_bld;
        n_ph    = r_ph;
        n_dim   = r_dim;
        n_cnt   = r_cnt;
        n_top   = r_top;
        n_built = r_built;
        n_bad   = r_bad;
        n_sovf  = r_sovf;
        n_st    = r_st;
        n_prev  = r_prev;
        n_in    = r_in;
        n_acc   = r_acc;
        n_aux   = r_aux;
        n_mc    = r_mc;
        n_movf  = r_movf;
        n_sum   = r_sum;
        n_rem   = r_rem;
        n_oc    = r_oc;
        n_err   = r_err;

        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_in  = i_in;
                    n_oc  = '{default: '0};
                    n_sum = '0;
                    n_err = ndc_pkg::ERR_OK;
                    n_rem = i_in.linear_index;
                    n_dim = (i_in.op == ndc_pkg::OP_TO_COORD) ? r_top : '0;
                    if (r_bad) begin
                        n_err   = ndc_pkg::ERR_CFG;
                        n_state = S_DONE;
                    end else if (r_sovf) begin
                        n_err   = ndc_pkg::ERR_OVF;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DISP;
                    end
                end
            end
            S_BLD: begin
                n_bad   = w_cfg_bad;
                n_top   = w_top;
                n_built = (w_top == DW'(1)) ? DW'(2) : w_top;
                n_sovf  = 1'b0;
                n_st    = '{default: '0};
                n_dim   = '0;
                n_ph    = 1'b0;
                n_bld   = !w_cfg_bad;
                n_state = w_cfg_bad ? S_IDLE : S_DISP;
            end
            S_DISP: begin
                n_acc  = '0;
                n_movf = 1'b0;
                n_cnt  = MUL_LAST;
                if (r_bld) begin
                    if (r_dim == DW'(0) || r_dim == DW'(1)) begin
                        n_st[r_dim] = (r_dim == DW'(0)) ? IW'(1) : IW'(i_cfg.channel_count);
                        n_prev      = n_st[r_dim];
                        n_state     = w_bld_end ? S_IDLE : S_DISP;
                        n_bld       = !w_bld_end;
                        n_dim       = w_bld_end ? r_dim : DW'(r_dim + 1'b1);
                    end else if (r_dim == DW'(2)) begin
                        if (w_packed) begin
                            n_aux   = IW'(i_cfg.width_size) + IW'(PACK_BITS - 1);
                            n_mc    = IW'(PACK_BITS);
                            n_cnt   = DIV_LAST;
                            n_state = S_DIV;
                        end else begin
                            n_aux   = IW'(i_cfg.width_size);
                            n_mc    = IW'(i_cfg.channel_count);
                            n_state = S_MUL;
                        end
                    end else begin
                        n_aux   = IW'(w_sz[w_szi]);
                        n_mc    = r_prev;
                        n_state = S_MUL;
                    end
                end else if (r_in.op == ndc_pkg::OP_TO_INDEX) begin
                    n_aux   = IW'(w_crd[w_cri]);
                    n_mc    = r_st[r_dim];
                    n_state = S_MUL;
                end else if (r_st[r_dim] == '0) begin
                    n_state = w_lastd ? S_DONE : S_DISP;
                    n_dim   = w_lastd ? r_dim : DW'(r_dim - 1'b1);
                end else begin
                    n_aux   = r_rem;
                    n_mc    = r_st[r_dim];
                    n_cnt   = DIV_LAST;
                    n_state = S_DIV;
                end
            end
            S_MUL: begin
                n_acc  = w_stp.acc;
                n_aux  = w_stp.aux;
                n_movf = r_movf | w_stp.ovf;
                n_cnt  = ndc_pkg::CNT_W'(r_cnt - 1'b1);
                if (r_cnt == '0) begin
                    if (r_bld) begin
                        if (r_dim == DW'(2) && !r_ph) begin
                            n_ph   = 1'b1;
                            n_acc  = '0;
                            n_movf = 1'b0;
                            n_aux  = IW'(i_cfg.sample_bits[6:3]);
                            n_mc   = w_stp.acc;
                            n_cnt  = MUL_LAST;
                        end else begin
                            n_st[r_dim] = w_stp.acc;
                            n_prev      = w_stp.acc;
                            n_sovf      = r_sovf | r_movf | w_stp.ovf;
                            n_state     = w_bld_end ? S_IDLE : S_DISP;
                            n_bld       = !w_bld_end;
                            n_dim       = w_bld_end ? r_dim : DW'(r_dim + 1'b1);
                        end
                    end else begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD: begin
                n_sum = w_stp.acc;
                if (r_movf || w_stp.ovf) begin
                    n_err = ndc_pkg::ERR_OVF;
                end
                n_state = w_top_end ? S_DONE : S_DISP;
                n_dim   = w_top_end ? r_dim : DW'(r_dim + 1'b1);
            end
            S_DIV: begin
                n_acc = w_stp.acc;
                n_aux = w_stp.aux;
                n_cnt = ndc_pkg::CNT_W'(r_cnt - 1'b1);
                if (r_cnt == '0) begin
                    if (r_bld) begin
                        n_st[r_dim] = w_stp.aux;
                        n_prev      = w_stp.aux;
                        n_state     = w_bld_end ? S_IDLE : S_DISP;
                        n_bld       = !w_bld_end;
                        n_dim       = w_bld_end ? r_dim : DW'(r_dim + 1'b1);
                    end else begin
                        // saturate a quotient past 16 bits
                        n_oc[r_dim] = (w_stp.aux[IW-1:CW] != '0) ? '1 : w_stp.aux[CW-1:0];
                        n_rem       = w_stp.acc;
                        n_state     = w_lastd ? S_DONE : S_DISP;
                        n_dim       = w_lastd ? r_dim : DW'(r_dim - 1'b1);
                    end
                end
            end
            S_DONE: begin
                if (i_req.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_BLD;
            end
        endcase

        if (i_req.build) begin
            n_state = S_BLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BLD;
            r_bld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bld   <= n_bld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph    <= n_ph;
        r_dim   <= n_dim;
        r_cnt   <= n_cnt;
        r_top   <= n_top;
        r_built <= n_built;
        r_bad   <= n_bad;
        r_sovf  <= n_sovf;
        r_st    <= n_st;
        r_prev  <= n_prev;
        r_in    <= n_in;
        r_acc   <= n_acc;
        r_aux   <= n_aux;
        r_mc    <= n_mc;
        r_movf  <= n_movf;
        r_sum   <= n_sum;
        r_rem   <= n_rem;
        r_oc    <= n_oc;
        r_err   <= n_err;
    end

    for (genvar g = 0; g < ndc_pkg::NUM_AXES; g++) begin : g_oc
        if (g < NSLOT) begin : g_on
            assign w_ocf[g] = r_oc[g];
        end else begin : g_off
            assign w_ocf[g] = '0;
        end
    end

    assign w_ok_idx = (r_err == ndc_pkg::ERR_OK) && (r_in.op == ndc_pkg::OP_TO_INDEX);
    assign w_ok_crd = (r_err == ndc_pkg::ERR_OK) && (r_in.op == ndc_pkg::OP_TO_COORD);

    assign o_out.index_out  = w_ok_idx ? r_sum : '0;
    assign o_out.out_c      = w_ok_crd ? w_ocf[0] : '0;
    assign o_out.out_x      = w_ok_crd ? w_ocf[1] : '0;
    assign o_out.out_y      = w_ok_crd ? w_ocf[2] : '0;
    assign o_out.out_f      = w_ok_crd ? w_ocf[3] : '0;
    assign o_out.out_l      = w_ok_crd ? w_ocf[4] : '0;
    assign o_out.error_code = r_err;

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE);

endmodule
`default_nettype wire

/* rtl/ndc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_checker - port-level checks of the index/coordinate converter
// Watches the handshakes and result words on the top-level ports.
// ----------------------------------------------------------------------------
module ndc_checker (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    input  var logic                          i_in_valid,
    input  var logic                          o_in_ready,
    input  var logic                          o_out_valid,
    input  var logic                          i_out_ready,
    input  var ndc_pkg::t_out_word            o_out_word,
    input  var logic                          i_cfg_we
);

    logic w_err_set;

    assign w_err_set = (o_out_word.error_code != ndc_pkg::ERR_OK);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.error_code == ndc_pkg::ERR_OK
                      || o_out_word.error_code == ndc_pkg::ERR_CFG
                      || o_out_word.error_code == ndc_pkg::ERR_OVF))
        else $error("undefined error code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && w_err_set |-> o_out_word.index_out == '0
            && o_out_word.out_c == '0 && o_out_word.out_x == '0
            && o_out_word.out_y == '0 && o_out_word.out_f == '0
            && o_out_word.out_l == '0)
        else $error("fields not cleared on error");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while converting");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !o_in_ready)
        else $error("word taken during a configuration write");

endmodule

bind nd_index_coord_converter ndc_checker u_ndc_checker (.*);
`default_nettype wire
